>>> hw/rtl/hlbac_pkg.sv
// Shared types and constants for the FP16 argmax beat classifier.
// Depends on nothing; hlbac_front, hlbac_merge and the top level use it.
package hlbac_pkg;

  localparam int MAX_LANES  = 8;
  localparam int LANES_DEF  = 8;
  localparam int LANE_IDX_W = $clog2(MAX_LANES);
  localparam int CNT_W      = $clog2(MAX_LANES + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARTIAL  = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;
  localparam logic [1:0] ST_NO_LAST  = 2'd3;

  localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
  localparam logic [1:0] REG_WORD_CAPACITY = 2'd1;
  localparam logic [1:0] REG_BEAT_LIMIT    = 2'd2;

  localparam logic [7:0] CLASS_COUNT_RST   = 8'd10;
  localparam logic [7:0] WORD_CAPACITY_RST = 8'd16;
  localparam logic [6:0] BEAT_LIMIT_RST    = 7'd8;
  localparam logic [7:0] CLASS_MAX         = 8'd128;

  typedef struct packed {
    logic [15:0] lane0;
    logic [15:0] lane1;
    logic [15:0] lane2;
    logic [15:0] lane3;
    logic [15:0] lane4;
    logic [15:0] lane5;
    logic [15:0] lane6;
    logic [15:0] lane7;
    logic [15:0] byte_strobe;
    logic        is_last;
  } beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] best_class;
    logic [7:0] words_taken;
    logic [6:0] beats_taken;
  } result_t;

  typedef struct packed {
    logic [7:0] class_count;
    logic [7:0] word_capacity;
    logic [6:0] beat_limit;
  } cfg_t;

  // Per-beat lane summary handed from the lane stage to the merge stage.
  // pm_* entry k holds the best full lane among lanes below k.
  typedef struct packed {
    logic [MAX_LANES-1:0]                 full;
    logic [MAX_LANES-1:0]                 part;
    logic [MAX_LANES-1:0][CNT_W-1:0]      pre;
    logic [CNT_W-1:0]                     total;
    logic [MAX_LANES:0]                   pm_any;
    logic [MAX_LANES:0][15:0]             pm_key;
    logic [MAX_LANES:0][LANE_IDX_W-1:0]   pm_lane;
    logic                                 last;
  } lane_info_t;

endpackage

>>> hw/rtl/hlbac_lane.sv
// One lane core: strobe decode and FP16 order key.
// Depends on nothing outside this file.
module hlbac_lane (
  input  logic [15:0] word,
  input  logic [1:0]  strobe,
  output logic        full,
  output logic        part,
  output logic [15:0] key
);

  // Negative halves are inverted, positive ones get the sign flipped, so an
  // unsigned compare of keys follows the numeric order.
  function automatic logic [15:0] order_key(input logic [15:0] h);
    return h[15] ? ~h : (h ^ 16'h8000);
  endfunction

  assign full = &strobe;
  assign part = ^strobe;
  assign key  = order_key(word);

endmodule

>>> hw/rtl/hlbac_front.sv
// Lane stage: runs the lane cores side by side and registers prefix counts
// and prefix maxima of the beat. Depends on hlbac_pkg and hlbac_lane.
module hlbac_front #(
  parameter int LANES = hlbac_pkg::LANES_DEF
) (
  input  logic                    clk,
  input  logic                    load,
  input  hlbac_pkg::beat_t        beat,
  output hlbac_pkg::lane_info_t   info
);

  logic [hlbac_pkg::MAX_LANES-1:0][15:0] words;
  logic [hlbac_pkg::MAX_LANES-1:0][15:0] keys;
  logic [hlbac_pkg::MAX_LANES-1:0]       full;
  logic [hlbac_pkg::MAX_LANES-1:0]       part;
  hlbac_pkg::lane_info_t                 info_next;

  assign words = {beat.lane7, beat.lane6, beat.lane5, beat.lane4,
                  beat.lane3, beat.lane2, beat.lane1, beat.lane0};

  for (genvar i = 0; i < hlbac_pkg::MAX_LANES; i++) begin : g_lane
    if (i < LANES) begin : g_used
      hlbac_lane u_lane (
        .word   (words[i]),
        .strobe (beat.byte_strobe[2*i+1:2*i]),
        .full   (full[i]),
        .part   (part[i]),
        .key    (keys[i])
      );
    end else begin : g_unused
      assign full[i] = 1'b0;
      assign part[i] = 1'b0;
      assign keys[i] = 16'h0000;
    end
  end

  always_comb begin
    logic [hlbac_pkg::CNT_W-1:0] cnt;
    logic                        take;
    cnt               = '0;
    info_next.full    = full;
    info_next.part    = part;
    info_next.last    = beat.is_last;
    info_next.pm_any[0]  = 1'b0;
    info_next.pm_key[0]  = 16'h0000;
    info_next.pm_lane[0] = '0;
    for (int i = 0; i < hlbac_pkg::MAX_LANES; i++) begin
      info_next.pre[i] = cnt;
      cnt = cnt + hlbac_pkg::CNT_W'(full[i]);
      // Strict compare keeps the earlier lane on a tie.
      take = full[i] && (!info_next.pm_any[i] || (keys[i] > info_next.pm_key[i]));
      info_next.pm_any[i+1]  = info_next.pm_any[i] | full[i];
      info_next.pm_key[i+1]  = take ? keys[i] : info_next.pm_key[i];
      info_next.pm_lane[i+1] = take ? hlbac_pkg::LANE_IDX_W'(i) : info_next.pm_lane[i];
    end
    info_next.total = cnt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      info <= info_next;
    end
  end

endmodule

>>> hw/rtl/hlbac_merge.sv
// Merge stage: combines the lane summary with the run state, finds the first
// lane error and the new best word. Depends on hlbac_pkg.
module hlbac_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  hlbac_pkg::lane_info_t  info,
  input  hlbac_pkg::cfg_t        cfg,
  output logic                   emit,
  output hlbac_pkg::result_t     res
);

  logic [7:0]  word_counter;
  logic [6:0]  beat_counter;
  logic [6:0]  best_index;
  logic [15:0] best_key;

  logic [7:0]  word_counter_next;
  logic [6:0]  beat_counter_next;
  logic [6:0]  best_index_next;
  logic [15:0] best_key_next;

  logic [7:0]                          classes;
  logic [8:0]                          wc9;
  logic [hlbac_pkg::MAX_LANES-1:0]     err;
  logic [hlbac_pkg::MAX_LANES-1:0]     cls_stop;
  logic                                has_err;
  logic [hlbac_pkg::LANE_IDX_W-1:0]    err_lane;
  logic [hlbac_pkg::CNT_W-1:0]         cut;
  logic [8:0]                          win_idx;
  logic                                take;
  logic [6:0]                          bi_upd;
  logic [15:0]                         bk_upd;
  logic [8:0]                          words_err;
  logic [8:0]                          words_all;
  logic [6:0]                          bc_inc;

  assign classes = (cfg.class_count > hlbac_pkg::CLASS_MAX) ? hlbac_pkg::CLASS_MAX
                                                            : cfg.class_count;
  assign wc9 = {1'b0, word_counter};

  always_comb begin
    logic [8:0] idx;
    for (int i = 0; i < hlbac_pkg::MAX_LANES; i++) begin
      idx         = wc9 + 9'(info.pre[i]);
      err[i]      = info.part[i] || (info.full[i] && (idx >= {1'b0, cfg.word_capacity}));
      cls_stop[i] = info.full[i] && (idx >= {1'b0, classes});
    end
  end

  // Word indexes rise with the lane, so the argmax candidates are exactly the
  // full lanes below the first lane that errs or reaches the class count.
  always_comb begin
    has_err  = 1'b0;
    err_lane = '0;
    cut      = hlbac_pkg::CNT_W'(hlbac_pkg::MAX_LANES);
    for (int i = hlbac_pkg::MAX_LANES - 1; i >= 0; i--) begin
      if (err[i]) begin
        has_err  = 1'b1;
        err_lane = hlbac_pkg::LANE_IDX_W'(i);
      end
      if (err[i] || cls_stop[i]) begin
        cut = hlbac_pkg::CNT_W'(i);
      end
    end
  end

  assign win_idx   = wc9 + 9'(info.pre[info.pm_lane[cut]]);
  assign take      = info.pm_any[cut] && (info.pm_key[cut] > best_key);
  assign bi_upd    = take ? win_idx[6:0] : best_index;
  assign bk_upd    = take ? info.pm_key[cut] : best_key;
  assign words_err = wc9 + 9'(info.pre[err_lane]);
  assign words_all = wc9 + 9'(info.total);
  assign bc_inc    = beat_counter + 7'd1;

  always_comb begin
    emit            = 1'b0;
    res.status      = hlbac_pkg::ST_OK;
    res.best_class  = bi_upd;
    res.words_taken = words_all[7:0];
    res.beats_taken = bc_inc;
    if (has_err) begin
      emit            = 1'b1;
      res.status      = info.part[err_lane] ? hlbac_pkg::ST_PARTIAL
                                            : hlbac_pkg::ST_CAPACITY;
      res.words_taken = words_err[7:0];
      res.beats_taken = beat_counter;
    end else if (info.last) begin
      emit = 1'b1;
    end else if (bc_inc >= cfg.beat_limit) begin
      emit       = 1'b1;
      res.status = hlbac_pkg::ST_NO_LAST;
    end
  end

  always_comb begin
    word_counter_next = word_counter;
    beat_counter_next = beat_counter;
    best_index_next   = best_index;
    best_key_next     = best_key;
    if (fire) begin
      if (emit) begin
        word_counter_next = '0;
        beat_counter_next = '0;
        best_index_next   = '0;
        best_key_next     = '0;
      end else begin
        word_counter_next = words_all[7:0];
        beat_counter_next = bc_inc;
        best_index_next   = bi_upd;
        best_key_next     = bk_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter <= '0;
      beat_counter <= '0;
      best_index   <= '0;
      best_key     <= '0;
    end else begin
      word_counter <= word_counter_next;
      beat_counter <= beat_counter_next;
      best_index   <= best_index_next;
      best_key     <= best_key_next;
    end
  end

endmodule

>>> hw/rtl/half_lane_beat_argmax_classifier.sv
// FP16 argmax classifier over strobed stream beats, top level.
// The beat that ends a run passes the lane-stage register, then the result
// register. Throughput: one beat per cycle unless a finished result is held
// back; the merge stage updates its run counters and best key for each beat.
// Reset (synchronous, rst high) clears the run state and both pipeline valids
// and loads the registers with their defaults. Uses hlbac_pkg.
module half_lane_beat_argmax_classifier #(
  parameter int LANES = hlbac_pkg::LANES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  output logic                beat_stall,
  input  hlbac_pkg::beat_t    beat,
  output logic                result_valid,
  input  logic                result_stall,
  output hlbac_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  hlbac_pkg::cfg_t        cfg;
  hlbac_pkg::lane_info_t  info;
  hlbac_pkg::result_t     res;
  logic                   s1_valid;
  logic                   advance;
  logic                   fire;
  logic                   load;
  logic                   emit;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign fire       = s1_valid && advance;
  assign beat_stall = s1_valid && !advance;
  assign load       = beat_valid && !beat_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_count   <= hlbac_pkg::CLASS_COUNT_RST;
      cfg.word_capacity <= hlbac_pkg::WORD_CAPACITY_RST;
      cfg.beat_limit    <= hlbac_pkg::BEAT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hlbac_pkg::REG_CLASS_COUNT:   cfg.class_count   <= cfg_data;
        hlbac_pkg::REG_WORD_CAPACITY: cfg.word_capacity <= cfg_data;
        hlbac_pkg::REG_BEAT_LIMIT:    cfg.beat_limit    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  hlbac_front #(
    .LANES (LANES)
  ) u_front (
    .clk  (clk),
    .load (load),
    .beat (beat),
    .info (info)
  );

  hlbac_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .info (info),
    .cfg  (cfg),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        result_valid <= emit;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= res;
    end
  end

`ifndef ASSERT_OFF
  // The input side only waits while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    beat_stall |-> (result_valid && result_stall))
    else $error("beat stalled without a held result");

  // A run that ends on a beat boundary always counts that beat.
  a_beats_counted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == hlbac_pkg::ST_OK ||
                      result.status == hlbac_pkg::ST_NO_LAST))
    |-> (result.beats_taken != 7'd0))
    else $error("run ended without a counted beat");

  // A taken result with nothing in the lane stage leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !s1_valid) |=> !result_valid)
    else $error("result appeared without a beat in flight");
`endif

endmodule
